>>> hw/rtl/ter_pkg.sv
`timescale 1ns / 1ps

package ter_pkg;

  // Command carried in tuser on the input stream
  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } ter_cmd_e;

  localparam int unsigned REG_W     = 12;
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned ADDR_W    = 22;
  localparam int unsigned COLOR_W   = 16;

  localparam logic [REG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] CANVAS_WIDTH_RST  = 12'd240;
  localparam logic [REG_W-1:0] CANVAS_HEIGHT_RST = 12'd240;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  // Head of the command queue as seen by the scan controller
  typedef struct packed {
    logic     valid;
    ter_cmd_e cmd;
  } ter_head_t;

endpackage

>>> hw/rtl/ter_cmd_fifo.sv
`timescale 1ns / 1ps

module ter_cmd_fifo #(
  parameter int unsigned DATA_W = 88
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_cmd_i,
  input  logic [DATA_W-1:0]     in_data_i,
  input  logic                  pop_i,
  output ter_pkg::ter_head_t    head_o,
  output logic [DATA_W-1:0]     head_data_o
);

  logic [DATA_W-1:0]                 data_q [ter_pkg::FIFO_DEPTH];
  ter_pkg::ter_cmd_e                 cmd_q  [ter_pkg::FIFO_DEPTH];
  logic [ter_pkg::FIFO_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [ter_pkg::FIFO_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [ter_pkg::FIFO_CNT_W-1:0]    count_q, count_d;
  logic                              push;
  logic                              pop;

  assign in_ready_o = (count_q != ter_pkg::FIFO_CNT_W'(ter_pkg::FIFO_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = cmd_q[rd_ptr_q];
  assign head_data_o  = data_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Classify the beat by its command on entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= in_data_i;
      cmd_q[wr_ptr_q]  <= ter_pkg::ter_cmd_e'(in_cmd_i);
    end
  end

endmodule

>>> hw/rtl/ter_scan_ctrl.sv
`timescale 1ns / 1ps

module ter_scan_ctrl #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ter_pkg::ter_head_t             head_i,
  input  logic [6*COORD_BITS+ter_pkg::COLOR_W-1:0] head_data_i,
  output logic                           pop_o,
  input  logic                           adv_i,
  output logic                           issue_o,
  output logic                           last_o,
  output logic [COORD_BITS-1:0]          px_o,
  output logic [COORD_BITS-1:0]          py_o,
  output logic [COORD_BITS-1:0]          vtx_o [6],
  output logic [ter_pkg::COLOR_W-1:0]    color_o
);

  localparam int unsigned CB = COORD_BITS;

  logic [CB-1:0]               vtx_q [6];
  logic [CB-1:0]               min_x_q, max_x_q, min_y_q, max_y_q;
  logic [CB-1:0]               scan_x_q, scan_x_d;
  logic [CB-1:0]               scan_y_q, scan_y_d;
  logic [ter_pkg::COLOR_W-1:0] color_q;
  logic                        active_q, active_d;
  logic [CB-1:0]               in_vtx [6];
  logic [CB-1:0]               box_min_x, box_max_x, box_min_y, box_max_y;
  logic                        do_load;
  logic                        do_step;
  logic                        at_last;

  function automatic logic [CB-1:0] min3(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                         input logic [CB-1:0] c);
    logic [CB-1:0] m;
    m = ($signed(a) < $signed(b)) ? a : b;
    return ($signed(m) < $signed(c)) ? m : c;
  endfunction

  function automatic logic [CB-1:0] max3(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                         input logic [CB-1:0] c);
    logic [CB-1:0] m;
    m = ($signed(a) > $signed(b)) ? a : b;
    return ($signed(m) > $signed(c)) ? m : c;
  endfunction

  for (genvar i = 0; i < 6; i++) begin : g_vtx
    assign in_vtx[i] = head_data_i[i*CB +: CB];
    assign vtx_o[i]  = vtx_q[i];
  end

  assign box_min_x = min3(in_vtx[0], in_vtx[2], in_vtx[4]);
  assign box_max_x = max3(in_vtx[0], in_vtx[2], in_vtx[4]);
  assign box_min_y = min3(in_vtx[1], in_vtx[3], in_vtx[5]);
  assign box_max_y = max3(in_vtx[1], in_vtx[3], in_vtx[5]);

  // A load never waits on the pipeline; a step waits for a free slot
  assign do_load = head_i.valid && (head_i.cmd == ter_pkg::CMD_LOAD);
  assign do_step = head_i.valid && (head_i.cmd == ter_pkg::CMD_STEP) && adv_i;
  assign pop_o   = do_load || do_step;
  assign at_last = (scan_x_q == max_x_q) && (scan_y_q == max_y_q);

  assign issue_o = do_step && active_q;
  assign last_o  = at_last;
  assign px_o    = scan_x_q;
  assign py_o    = scan_y_q;
  assign color_o = color_q;

  always_comb begin
    scan_x_d = scan_x_q;
    scan_y_d = scan_y_q;
    active_d = active_q;
    if (do_load) begin
      scan_x_d = box_min_x;
      scan_y_d = box_min_y;
      active_d = 1'b1;
    end else if (issue_o) begin
      if (at_last) begin
        active_d = 1'b0;
      end else if ($signed(scan_x_q) < $signed(max_x_q)) begin
        scan_x_d = scan_x_q + 1'b1;
      end else begin
        scan_x_d = min_x_q;
        scan_y_d = scan_y_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      scan_x_q <= '0;
      scan_y_q <= '0;
    end else begin
      active_q <= active_d;
      scan_x_q <= scan_x_d;
      scan_y_q <= scan_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      for (int i = 0; i < 6; i++) begin
        vtx_q[i] <= in_vtx[i];
      end
      min_x_q <= box_min_x;
      max_x_q <= box_max_x;
      min_y_q <= box_min_y;
      max_y_q <= box_max_y;
      color_q <= head_data_i[6*CB +: ter_pkg::COLOR_W];
    end
  end

endmodule

>>> hw/rtl/ter_edge_pipe.sv
`timescale 1ns / 1ps

module ter_edge_pipe #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          issue_i,
  input  logic                          last_i,
  input  logic [COORD_BITS-1:0]         px_i,
  input  logic [COORD_BITS-1:0]         py_i,
  input  logic [COORD_BITS-1:0]         vtx_i [6],
  input  logic [ter_pkg::COLOR_W-1:0]   color_i,
  input  logic [ter_pkg::REG_W-1:0]     canvas_w_i,
  input  logic [ter_pkg::REG_W-1:0]     canvas_h_i,
  output logic                          adv_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [COORD_BITS-1:0]         out_x_o,
  output logic [COORD_BITS-1:0]         out_y_o,
  output logic [ter_pkg::ADDR_W-1:0]    out_addr_o,
  output logic                          out_draw_o,
  output logic [ter_pkg::COLOR_W-1:0]   out_color_o,
  output logic                          out_last_o
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned DW    = CB + 1;
  localparam int unsigned PW    = 2 * CB + 2;
  localparam int unsigned EW    = PW + 1;
  localparam int unsigned CMP_W = (CB > ter_pkg::REG_W) ? CB : ter_pkg::REG_W;
  localparam int unsigned YW_W  = CB + ter_pkg::REG_W;
  localparam int unsigned SUM_W = (YW_W + 1 > ter_pkg::ADDR_W) ? YW_W + 1 : ter_pkg::ADDR_W;

  // Edge order: B->C, C->A, A->B as (start, end) vertex indexes
  localparam int EDGE_A [3] = '{1, 2, 0};
  localparam int EDGE_B [3] = '{2, 0, 1};

  logic signed [DW-1:0]        ex_u [3];
  logic signed [DW-1:0]        ex_v [3];
  logic signed [DW-1:0]        ex_s [3];
  logic signed [DW-1:0]        ex_t [3];
  logic                        on_canvas;

  logic                        s1_valid_q;
  logic signed [DW-1:0]        s1_u_q [3];
  logic signed [DW-1:0]        s1_v_q [3];
  logic signed [DW-1:0]        s1_s_q [3];
  logic signed [DW-1:0]        s1_t_q [3];
  logic [CB-1:0]               s1_x_q, s1_y_q;
  logic [ter_pkg::COLOR_W-1:0] s1_color_q;
  logic                        s1_last_q, s1_canvas_q;
  logic [ter_pkg::REG_W-1:0]   s1_w_q;

  logic                        s2_valid_q;
  logic signed [PW-1:0]        s2_p_q [3];
  logic signed [PW-1:0]        s2_q_q [3];
  logic [YW_W-1:0]             s2_yw_q;
  logic [CB-1:0]               s2_x_q, s2_y_q;
  logic [ter_pkg::COLOR_W-1:0] s2_color_q;
  logic                        s2_last_q, s2_canvas_q;

  logic signed [EW-1:0]        edge_val [3];
  logic [2:0]                  ge_zero, le_zero;
  logic                        draw;
  logic [SUM_W-1:0]            addr_sum;

  logic                        o_valid_q;
  logic [CB-1:0]               o_x_q, o_y_q;
  logic [ter_pkg::ADDR_W-1:0]  o_addr_q;
  logic                        o_draw_q, o_last_q;
  logic [ter_pkg::COLOR_W-1:0] o_color_q;

  // Whole pipe moves when the output slot is free or being taken
  assign adv_o = !o_valid_q || out_ready_i;

  for (genvar e = 0; e < 3; e++) begin : g_diff
    assign ex_u[e] = $signed({vtx_i[2*EDGE_B[e]][CB-1], vtx_i[2*EDGE_B[e]]})
                   - $signed({vtx_i[2*EDGE_A[e]][CB-1], vtx_i[2*EDGE_A[e]]});
    assign ex_v[e] = $signed({py_i[CB-1], py_i})
                   - $signed({vtx_i[2*EDGE_A[e]+1][CB-1], vtx_i[2*EDGE_A[e]+1]});
    assign ex_s[e] = $signed({vtx_i[2*EDGE_B[e]+1][CB-1], vtx_i[2*EDGE_B[e]+1]})
                   - $signed({vtx_i[2*EDGE_A[e]+1][CB-1], vtx_i[2*EDGE_A[e]+1]});
    assign ex_t[e] = $signed({px_i[CB-1], px_i})
                   - $signed({vtx_i[2*EDGE_A[e]][CB-1], vtx_i[2*EDGE_A[e]]});
  end

  assign on_canvas = !px_i[CB-1] && !py_i[CB-1]
                  && (CMP_W'(px_i) < CMP_W'(canvas_w_i))
                  && (CMP_W'(py_i) < CMP_W'(canvas_h_i));

  for (genvar e = 0; e < 3; e++) begin : g_edge
    assign edge_val[e] = EW'(s2_p_q[e]) - EW'(s2_q_q[e]);
    assign ge_zero[e]  = !edge_val[e][EW-1];
    assign le_zero[e]  = edge_val[e][EW-1] || (edge_val[e] == '0);
  end

  assign draw     = s2_canvas_q && ((&ge_zero) || (&le_zero));
  assign addr_sum = SUM_W'(s2_yw_q) + SUM_W'(s2_x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else if (adv_o) begin
      s1_valid_q <= issue_i;
      s2_valid_q <= s1_valid_q;
      o_valid_q  <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      for (int e = 0; e < 3; e++) begin
        s1_u_q[e] <= ex_u[e];
        s1_v_q[e] <= ex_v[e];
        s1_s_q[e] <= ex_s[e];
        s1_t_q[e] <= ex_t[e];
        s2_p_q[e] <= PW'(s1_u_q[e] * s1_v_q[e]);
        s2_q_q[e] <= PW'(s1_s_q[e] * s1_t_q[e]);
      end
      s1_x_q      <= px_i;
      s1_y_q      <= py_i;
      s1_color_q  <= color_i;
      s1_last_q   <= last_i;
      s1_canvas_q <= on_canvas;
      s1_w_q      <= canvas_w_i;

      s2_yw_q     <= YW_W'(s1_y_q) * YW_W'(s1_w_q);
      s2_x_q      <= s1_x_q;
      s2_y_q      <= s1_y_q;
      s2_color_q  <= s1_color_q;
      s2_last_q   <= s1_last_q;
      s2_canvas_q <= s1_canvas_q;

      o_x_q     <= s2_x_q;
      o_y_q     <= s2_y_q;
      o_draw_q  <= draw;
      o_addr_q  <= draw ? addr_sum[ter_pkg::ADDR_W-1:0] : '0;
      o_color_q <= s2_color_q;
      o_last_q  <= s2_last_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_x_o     = o_x_q;
  assign out_y_o     = o_y_q;
  assign out_addr_o  = o_addr_q;
  assign out_draw_o  = o_draw_q;
  assign out_color_o = o_color_q;
  assign out_last_o  = o_last_q;

endmodule

>>> hw/rtl/triangle_edge_rasterizer.sv
`timescale 1ns / 1ps

// Edge-function triangle rasterizer.
// Input stream: tuser[0] is the command (0 load, 1 step); tdata carries the
// six vertex coordinates and the fill color. A load sets up a triangle and
// its bounding box and returns nothing; each step emits one beat for the
// next box position in row-major order, with draw in tuser and last in tlast.
// A step with no scan in progress is consumed and emits nothing.
// Commands enter a two-entry queue; the scan controller drains it and feeds
// a three-stage edge evaluation pipeline (differences, products, sign test and
// address). A step beat goes from the queue head through those stages in order, and
// one position is delivered per cycle in steady state while the receiver is ready.
// When the receiver stalls, the whole pipeline holds; the queue keeps taking
// beats until it is full, then s_axis_tready drops.
// Reset empties the queue and the pipeline, stops any scan and sets both
// canvas registers to 240. Write the canvas registers only while idle.
module triangle_edge_rasterizer #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ter_pkg::REG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ter_pkg::REG_W-1:0]            cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // ax, ay, bx, by, cx, cy, fill_color_in, zero pad
  input  logic [((6*COORD_BITS+16+7)/8)*8-1:0] s_axis_tdata,
  // command
  input  logic [0:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // pixel_x, pixel_y, pixel_address, color_out, zero pad
  output logic [((2*COORD_BITS+38+7)/8)*8-1:0] m_axis_tdata,
  // draw
  output logic [0:0]                           m_axis_tuser,
  output logic                                 m_axis_tlast
);

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned PLD_W  = 6 * CB + ter_pkg::COLOR_W;
  localparam int unsigned OUT_W  = ((2 * CB + 38 + 7) / 8) * 8;
  localparam int unsigned OPLD_W = 2 * CB + ter_pkg::ADDR_W + ter_pkg::COLOR_W;

  logic [ter_pkg::REG_W-1:0]   canvas_w_q, canvas_h_q;
  ter_pkg::ter_head_t          head;
  logic [PLD_W-1:0]            head_data;
  logic                        pop;
  logic                        adv;
  logic                        issue;
  logic                        scan_last;
  logic [CB-1:0]               px, py;
  logic [CB-1:0]               vtx [6];
  logic [ter_pkg::COLOR_W-1:0] color;
  logic [CB-1:0]               out_x, out_y;
  logic [ter_pkg::ADDR_W-1:0]  out_addr;
  logic [ter_pkg::COLOR_W-1:0] out_color;
  logic                        out_draw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= ter_pkg::CANVAS_WIDTH_RST;
      canvas_h_q <= ter_pkg::CANVAS_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ter_pkg::REG_CANVAS_WIDTH:  canvas_w_q <= cfg_data_i;
        ter_pkg::REG_CANVAS_HEIGHT: canvas_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ter_cmd_fifo #(
    .DATA_W(PLD_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser[0]),
    .in_data_i  (s_axis_tdata[PLD_W-1:0]),
    .pop_i      (pop),
    .head_o     (head),
    .head_data_o(head_data)
  );

  ter_scan_ctrl #(
    .COORD_BITS(CB)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .head_data_i(head_data),
    .pop_o      (pop),
    .adv_i      (adv),
    .issue_o    (issue),
    .last_o     (scan_last),
    .px_o       (px),
    .py_o       (py),
    .vtx_o      (vtx),
    .color_o    (color)
  );

  ter_edge_pipe #(
    .COORD_BITS(CB)
  ) u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .issue_i    (issue),
    .last_i     (scan_last),
    .px_i       (px),
    .py_i       (py),
    .vtx_i      (vtx),
    .color_i    (color),
    .canvas_w_i (canvas_w_q),
    .canvas_h_i (canvas_h_q),
    .adv_o      (adv),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_x_o    (out_x),
    .out_y_o    (out_y),
    .out_addr_o (out_addr),
    .out_draw_o (out_draw),
    .out_color_o(out_color),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'(OPLD_W'({out_color, out_addr, out_y, out_x}));
  assign m_axis_tuser = out_draw;

endmodule

>>> sim/raster_checker.sv
`timescale 1ns / 1ps

module raster_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [ter_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [ter_pkg::REG_W-1:0]     cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // ax, ay, bx, by, cx, cy, fill_color_in
  input  logic [87:0] s_axis_tdata,
  // command
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_x, pixel_y, pixel_address, color_out, zero pad
  input  logic [63:0] m_axis_tdata,
  // draw
  input  logic [0:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          error_count_o,
  output int          pending_o
);

  localparam int CB = 12;

  typedef struct {
    logic signed [CB-1:0]        px;
    logic signed [CB-1:0]        py;
    logic [ter_pkg::ADDR_W-1:0]  addr;
    logic                        draw;
    logic [ter_pkg::COLOR_W-1:0] color;
    logic                        last;
  } pixel_t;

  pixel_t expected_pixels[$];

  // Predicted state of the block
  logic signed [CB-1:0]        tri_vtx[6];   // ax, ay, bx, by, cx, cy
  logic signed [CB-1:0]        tri_box[4];   // min x, max x, min y, max y
  logic signed [CB-1:0]        scan_x, scan_y;
  logic [ter_pkg::COLOR_W-1:0] held_color;
  logic                        scan_on;
  logic [ter_pkg::REG_W-1:0]   canvas_w, canvas_h;

  int errors = 0;
  assign error_count_o = errors;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic longint edge_val(input longint ax, input longint ay, input longint bx,
                                      input longint by, input longint px, input longint py);
    return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
  endfunction

  function automatic logic signed [CB-1:0] min3(input logic signed [CB-1:0] a,
                                                 input logic signed [CB-1:0] b,
                                                 input logic signed [CB-1:0] c);
    logic signed [CB-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [CB-1:0] max3(input logic signed [CB-1:0] a,
                                                 input logic signed [CB-1:0] b,
                                                 input logic signed [CB-1:0] c);
    logic signed [CB-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want, got;
    longint xl, yl, wl, hl, w0, w1, w2, lin;
    bit in_tri, on_canvas;
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) tri_vtx[i] = '0;
      for (int i = 0; i < 4; i++) tri_box[i] = '0;
      scan_x = '0;
      scan_y = '0;
      held_color = '0;
      scan_on = 1'b0;
      canvas_w = ter_pkg::CANVAS_WIDTH_RST;
      canvas_h = ter_pkg::CANVAS_HEIGHT_RST;
      expected_pixels.delete();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.px    = m_axis_tdata[11:0];
        got.py    = m_axis_tdata[23:12];
        got.addr  = m_axis_tdata[45:24];
        got.color = m_axis_tdata[61:46];
        got.draw  = m_axis_tuser[0];
        got.last  = m_axis_tlast;
        if (expected_pixels.size() == 0) begin
          report_mismatch("output beat with nothing pending, pixel_x", got.px, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (got.px !== want.px) report_mismatch("pixel_x", got.px, want.px);
          if (got.py !== want.py) report_mismatch("pixel_y", got.py, want.py);
          if (got.addr !== want.addr) report_mismatch("pixel_address", got.addr, want.addr);
          if (got.draw !== want.draw) report_mismatch("draw", got.draw, want.draw);
          if (got.color !== want.color) report_mismatch("color_out", got.color, want.color);
          if (got.last !== want.last) report_mismatch("last", got.last, want.last);
          if (m_axis_tdata[63:62] !== 2'b00) report_mismatch("tdata pad", m_axis_tdata[63:62], 0);
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          ter_pkg::REG_CANVAS_WIDTH:  canvas_w = cfg_data_i;
          ter_pkg::REG_CANVAS_HEIGHT: canvas_h = cfg_data_i;
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (ter_pkg::ter_cmd_e'(s_axis_tuser) == ter_pkg::CMD_LOAD) begin
          for (int i = 0; i < 6; i++) tri_vtx[i] = s_axis_tdata[i*CB +: CB];
          tri_box[0] = min3(tri_vtx[0], tri_vtx[2], tri_vtx[4]);
          tri_box[1] = max3(tri_vtx[0], tri_vtx[2], tri_vtx[4]);
          tri_box[2] = min3(tri_vtx[1], tri_vtx[3], tri_vtx[5]);
          tri_box[3] = max3(tri_vtx[1], tri_vtx[3], tri_vtx[5]);
          held_color = s_axis_tdata[87:72];
          scan_x = tri_box[0];
          scan_y = tri_box[2];
          scan_on = 1'b1;
        end else if (scan_on) begin
          xl = scan_x;
          yl = scan_y;
          wl = canvas_w;
          hl = canvas_h;
          w0 = edge_val(tri_vtx[2], tri_vtx[3], tri_vtx[4], tri_vtx[5], xl, yl);
          w1 = edge_val(tri_vtx[4], tri_vtx[5], tri_vtx[0], tri_vtx[1], xl, yl);
          w2 = edge_val(tri_vtx[0], tri_vtx[1], tri_vtx[2], tri_vtx[3], xl, yl);
          // either winding counts as inside
          in_tri = (w0 >= 0 && w1 >= 0 && w2 >= 0) || (w0 <= 0 && w1 <= 0 && w2 <= 0);
          on_canvas = xl >= 0 && yl >= 0 && xl < wl && yl < hl;
          lin = yl * wl + xl;
          want.px    = scan_x;
          want.py    = scan_y;
          want.draw  = in_tri && on_canvas;
          want.addr  = want.draw ? lin[ter_pkg::ADDR_W-1:0] : '0;
          want.color = held_color;
          want.last  = (scan_x == tri_box[1]) && (scan_y == tri_box[3]);
          expected_pixels.push_back(want);
          // advance in row-major order, x fastest
          if (want.last) begin
            scan_on = 1'b0;
          end else if (scan_x < tri_box[1]) begin
            scan_x = scan_x + 1'b1;
          end else begin
            scan_x = tri_box[0];
            scan_y = scan_y + 1'b1;
          end
        end
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

>>> sim/triangle_edge_rasterizer_tb.sv
`timescale 1ns / 1ps

module triangle_edge_rasterizer_tb;

  localparam int CB          = 12;
  localparam int S_W         = ((6*CB+16+7)/8)*8;
  localparam int M_W         = ((2*CB+38+7)/8)*8;
  localparam int NUM_ITEMS   = 950;
  localparam int NUM_PHASES  = 8;
  localparam int DRAIN_WAIT  = 12;
  localparam int STALL_LIMIT = 2000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [ter_pkg::REG_IDX_W-1:0] cfg_idx_i = ter_pkg::REG_CANVAS_WIDTH;
  logic [ter_pkg::REG_W-1:0]     cfg_data_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [S_W-1:0]                s_axis_tdata = '0;
  logic [0:0]                    s_axis_tuser = ter_pkg::CMD_STEP;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [M_W-1:0]                m_axis_tdata;
  logic [0:0]                    m_axis_tuser;
  logic                          m_axis_tlast;

  int  errors;
  int  pending;
  int  items = 0;
  int  canvas_w = ter_pkg::CANVAS_WIDTH_RST;
  int  canvas_h = ter_pkg::CANVAS_HEIGHT_RST;
  bit  src_calm = 1'b0;
  bit  snk_calm = 1'b0;
  int  idle_cycles = 0;
  int  phase_w[NUM_PHASES] = '{1, 2048, 0, 4095, 17, 2048, 1, 240};
  int  phase_h[NUM_PHASES] = '{1, 2048, 0, 4095, 2048, 3, 1, 240};

  always #4 clk_i = ~clk_i;

  triangle_edge_rasterizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  raster_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .error_count_o (errors),
    .pending_o     (pending)
  );

  function automatic int pick_gap(input bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  // Small-triangle corner: near canvas edges, at the coordinate extremes or anywhere
  function automatic int pick_base(input int limit);
    int b;
    case ($urandom_range(0, 5))
      0: b = int'($urandom_range(0, 5)) - 4;
      1: b = limit - 4 + int'($urandom_range(0, 3));
      2: b = -2048;
      3: b = 2042;
      4: b = int'($urandom_range(0, 4090)) - 2048;
      default: b = int'($urandom_range(0, 40));
    endcase
    if (b > 2042) b = 2042;
    if (b < -2048) b = -2048;
    return b;
  endfunction

  task automatic drive_beat(input ter_pkg::ter_cmd_e cmd, input logic [S_W-1:0] data);
    int gap;
    gap = pick_gap(src_calm);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    items++;
  endtask

  task automatic send_step();
    logic [95:0] noise;
    noise = {$urandom(), $urandom(), $urandom()};
    drive_beat(ter_pkg::CMD_STEP, noise[S_W-1:0]);
  endtask

  task automatic run_triangle(input int v[6], input logic [15:0] color, input int steps);
    logic [S_W-1:0] beat;
    beat = '0;
    for (int i = 0; i < 6; i++) beat[i*CB +: CB] = v[i][CB-1:0];
    beat[6*CB +: 16] = color;
    drive_beat(ter_pkg::CMD_LOAD, beat);
    repeat (steps) send_step();
  endtask

  task automatic random_triangle();
    int v[6];
    int spread, bx, by, steps, area;
    int lo_x, hi_x, lo_y, hi_y;
    src_calm = ($urandom_range(0, 3) == 0);
    snk_calm = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 5) == 0) begin
      // wide triangle anywhere, scanned only for a few positions
      for (int i = 0; i < 6; i++) v[i] = int'($urandom_range(0, 4095)) - 2048;
      steps = $urandom_range(1, 8);
    end else begin
      spread = $urandom_range(0, 5);
      bx = pick_base(canvas_w);
      by = pick_base(canvas_h);
      for (int i = 0; i < 6; i += 2) begin
        v[i]   = bx + int'($urandom_range(0, spread));
        v[i+1] = by + int'($urandom_range(0, spread));
      end
      lo_x = v[0]; hi_x = v[0]; lo_y = v[1]; hi_y = v[1];
      for (int i = 2; i < 6; i += 2) begin
        if (v[i] < lo_x) lo_x = v[i];
        if (v[i] > hi_x) hi_x = v[i];
        if (v[i+1] < lo_y) lo_y = v[i+1];
        if (v[i+1] > hi_y) hi_y = v[i+1];
      end
      area = (hi_x - lo_x + 1) * (hi_y - lo_y + 1);
      // mostly run to the last position and a bit past it; sometimes cut short
      if ($urandom_range(0, 7) == 0) steps = $urandom_range(0, area - 1);
      else steps = area + int'($urandom_range(0, 2));
    end
    run_triangle(v, 16'($urandom_range(0, 65535)), steps);
  endtask

  // Drop valid and wait until every expected pixel is out and the pipe is empty
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ter_pkg::REG_IDX_W-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[ter_pkg::REG_W-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_canvas(input int w, input int h);
    int n;
    settle();
    write_reg(ter_pkg::REG_CANVAS_WIDTH, w);
    write_reg(ter_pkg::REG_CANVAS_HEIGHT, h);
    canvas_w = w;
    canvas_h = h;
    // continue any scan left open by the last phase under the new canvas
    n = $urandom_range(0, 3);
    repeat (n) send_step();
  endtask

  // Sink side: a random stall may come before each beat, none while calm
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = pick_gap(snk_calm);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part under the reset canvas
    send_step();
    run_triangle('{0, 0, 2, 0, 0, 2}, 16'hFFFF, 10);
    run_triangle('{-2048, -2048, 2047, 2047, -2048, 2047}, 16'h0000, 3);
    run_triangle('{5, 5, 5, 5, 5, 5}, 16'hA5A5, 1);
    run_triangle('{0, 7, 3, 7, 1, 7}, 16'h5A5A, 4);
    run_triangle('{2047, 2047, 2047, 2047, 2047, 2047}, 16'h8001, 1);

    phase_w[6] = $urandom_range(1, 2048);
    phase_h[6] = $urandom_range(1, 2048);
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_canvas(phase_w[p], phase_h[p]);
      while (items < (p + 1) * NUM_ITEMS / NUM_PHASES) random_triangle();
    end

    settle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
